### hdl/rabin_rolling_fingerprint_unit_macros.svh
// Assertion macros shared by the rolling fingerprint RTL.
`ifndef RABIN_ROLLING_FINGERPRINT_UNIT_MACROS_SVH
`define RABIN_ROLLING_FINGERPRINT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rrf_pkg.sv
// Shared types, constants and functions of the rolling fingerprint unit.
package rrf_pkg;

    // Configuration register indexes
    localparam logic CFG_POLYNOMIAL    = 1'b0;
    localparam logic CFG_WINDOW_LENGTH = 1'b1;

    // Register reset values
    localparam logic [63:0] POLY_RESET = 64'hBFE6_B8A5_BF37_8D83;
    localparam logic [6:0]  WLEN_RESET = 7'd48;

    // Item kinds carried in tuser
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef logic [7:0][63:0] basis_t;

    // Table status handed from the basis generator to the datapath
    typedef struct packed {
        logic       busy;
        logic [5:0] degree;
        logic [6:0] window_length;
        basis_t     append_basis;
        basis_t     remove_basis;
    } tables_t;

    // XOR of the basis words selected by the bits of idx
    function automatic logic [63:0] combine(input basis_t basis, input logic [7:0] idx);
        logic [63:0] acc;
        acc = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (idx[b])
                acc = acc ^ basis[b];
        end
        return acc;
    endfunction

endpackage

### hdl/rrf_basis_gen.sv
// Configuration registers and the sequencer that derives the T and U basis words.
module rrf_basis_gen #(
    parameter int MAX_WINDOW = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [63:0]      cfg_wdata,
    output rrf_pkg::tables_t tables
);

    typedef enum logic [4:0] {
        S_DEGREE = 5'b00001,
        S_APPEND = 5'b00010,
        S_POWER  = 5'b00100,
        S_REMOVE = 5'b01000,
        S_IDLE   = 5'b10000
    } gen_state_t;

    gen_state_t      state_reg, state_next;
    logic [63:0]     poly_reg, poly_next;
    logic [6:0]      wlen_reg, wlen_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [6:0]      byte_cnt_reg, byte_cnt_next;
    logic [5:0]      deg_reg, deg_next;
    logic [63:0]     r_reg, r_next;
    rrf_pkg::basis_t append_reg, append_next;
    rrf_pkg::basis_t remove_reg, remove_next;

    logic [63:0] r_times_x;
    logic [5:0]  deg_scan;
    logic [6:0]  high_idx;
    logic [63:0] high_word;
    logic        poly_ok;
    logic        wlen_ok;

    // Multiply the residue by x modulo the polynomial
    assign r_times_x = r_reg[deg_reg - 6'd1] ? ((r_reg << 1) ^ poly_reg) : (r_reg << 1);

    // Track the highest set coefficient while scanning
    assign deg_scan = poly_reg[cnt_reg] ? cnt_reg : deg_reg;

    // Explicit x^(k+b) term of the append basis, dropped past bit 63
    assign high_idx  = {1'b0, deg_reg} + {4'd0, cnt_reg[2:0]};
    assign high_word = high_idx[6] ? 64'd0 : (64'd1 << high_idx[5:0]);

    assign poly_ok = |cfg_wdata[63:8];
    assign wlen_ok = (cfg_wdata[6:0] != 7'd0) && (32'(cfg_wdata[6:0]) <= MAX_WINDOW);

    always_comb
    begin
        state_next    = state_reg;
        poly_next     = poly_reg;
        wlen_next     = wlen_reg;
        cnt_next      = cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        deg_next      = deg_reg;
        r_next        = r_reg;
        append_next   = append_reg;
        remove_next   = remove_reg;

        // Step the derivation sequence
        unique case (state_reg)
            S_DEGREE:
            begin
                deg_next = deg_scan;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    r_next     = poly_reg ^ (64'd1 << deg_scan);
                    cnt_next   = '0;
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                append_next[cnt_reg[2:0]] = r_reg | high_word;
                r_next   = r_times_x;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == 3'd7)
                begin
                    r_next        = 64'd1;
                    cnt_next      = '0;
                    byte_cnt_next = 7'd1;
                    state_next    = (wlen_reg == 7'd1) ? S_REMOVE : S_POWER;
                end
            end
            S_POWER:
            begin
                r_next   = r_times_x;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == 3'd7)
                begin
                    cnt_next      = '0;
                    byte_cnt_next = byte_cnt_reg + 7'd1;
                    if (byte_cnt_reg == wlen_reg - 7'd1)
                        state_next = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                remove_next[cnt_reg[2:0]] = r_reg;
                r_next   = r_times_x;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == 3'd7)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cnt_next = '0;
            end
            default:
            begin
                state_next = S_DEGREE;
                cnt_next   = '0;
            end
        endcase

        // Take a register write and restart the derivation
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rrf_pkg::CFG_POLYNOMIAL:
                begin
                    if (poly_ok)
                    begin
                        poly_next  = cfg_wdata;
                        state_next = S_DEGREE;
                        cnt_next   = '0;
                        deg_next   = '0;
                    end
                end
                rrf_pkg::CFG_WINDOW_LENGTH:
                begin
                    if (wlen_ok)
                    begin
                        wlen_next  = cfg_wdata[6:0];
                        state_next = S_DEGREE;
                        cnt_next   = '0;
                        deg_next   = '0;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_DEGREE;
            poly_reg     <= rrf_pkg::POLY_RESET;
            wlen_reg     <= rrf_pkg::WLEN_RESET;
            cnt_reg      <= '0;
            byte_cnt_reg <= '0;
            deg_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            poly_reg     <= poly_next;
            wlen_reg     <= wlen_next;
            cnt_reg      <= cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            deg_reg      <= deg_next;
        end
    end

    // Hold residue and basis words
    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        append_reg <= append_next;
        remove_reg <= remove_next;
    end

    assign tables.busy          = (state_reg != S_IDLE);
    assign tables.degree        = deg_reg;
    assign tables.window_length = wlen_reg;
    assign tables.append_basis  = append_reg;
    assign tables.remove_basis  = remove_reg;

endmodule

### hdl/rrf_window_store.sv
// Circular byte window: slot pointer, per-slot valid bits and read-first window memory.
module rrf_window_store #(
    parameter int MAX_WINDOW = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       clear,
    input  logic [7:0] data_byte,
    input  logic [6:0] window_length,
    output logic [7:0] old_byte
);

    localparam int SlotW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CmpW  = ((SlotW + 1) > 7) ? (SlotW + 1) : 7;

    logic [7:0]            mem [MAX_WINDOW];
    logic [SlotW-1:0]      slot_reg, slot_next;
    logic [MAX_WINDOW-1:0] valid_reg, valid_next;
    logic [7:0]            rd_reg;
    logic                  hit_reg;

    logic [CmpW-1:0]  slot_inc;
    logic [CmpW-1:0]  wlen_ext;
    logic [CmpW-1:0]  last_slot;
    logic             wrap;
    logic [SlotW-1:0] slot;
    logic             hit;

    // Advance the write slot with wrap at the window length
    assign slot_inc  = CmpW'(slot_reg) + CmpW'(1);
    assign wlen_ext  = CmpW'(window_length);
    assign last_slot = wlen_ext - CmpW'(1);
    assign wrap      = (slot_inc >= wlen_ext) || (slot_inc >= CmpW'(MAX_WINDOW));
    assign slot      = wrap ? '0 : slot_inc[SlotW-1:0];

    // A slot holds live data only if written since the last clear
    assign hit = valid_reg[slot];

    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        if (accept)
        begin
            if (clear)
            begin
                slot_next  = last_slot[SlotW-1:0];
                valid_next = '0;
            end
            else
            begin
                slot_next        = slot;
                valid_next[slot] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= SlotW'(rrf_pkg::WLEN_RESET - 7'd1);
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
            if (accept)
                hit_reg <= hit && !clear;
        end
    end

    // Read the departing byte and write the new one at the same slot
    always_ff @(posedge clk)
    begin
        if (accept && !clear)
            mem[slot] <= data_byte;
        if (accept)
            rd_reg <= mem[slot];
    end

    // A slot not written since the clear reads as zero
    assign old_byte = hit_reg ? rd_reg : 8'd0;

endmodule

### hdl/rabin_rolling_fingerprint_unit.sv
// Top level of the rolling Rabin fingerprint unit.
// Each item either pushes one byte into a sliding window of window_length bytes
// or clears the window, and yields one 64-bit fingerprint (0 after a clear).
// Items flow at one per clock unless the output stalls or the basis words are
// being derived: the window memory is read when an item is taken and the
// fingerprint is updated as it enters the output register; the rate rests on
// the fingerprint feedback through the two basis-word XOR trees. After reset
// and after every accepted register write the basis words are rederived and
// s_axis_tready stays low meanwhile: the degree scan, then the append basis
// words, the powers of x across the rest of the window and the remove basis
// words. The window memory needs no clearing pass; a valid bit per slot makes
// slots not written since reset or the last clear read as zero.
`include "rabin_rolling_fingerprint_unit_macros.svh"

module rabin_rolling_fingerprint_unit #(
    parameter int MAX_WINDOW = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] op
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] hash_value
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata
);

    rrf_pkg::tables_t tbl;

    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [63:0] hash_reg;

    logic        in_accept;
    logic        s1_adv;
    logic [7:0]  old_byte;
    logic [63:0] p_word;
    logic [5:0]  idx_shift;
    logic [63:0] p_shifted;
    logic [63:0] hash_push;
    logic [63:0] hash_next;

    rrf_basis_gen #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_basis_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tables    (tbl)
    );

    // Stage handshake: the read stage moves when the output register frees up
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !tbl.busy && (!s1_valid_reg || s1_adv);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    rrf_window_store #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_window_store (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .clear         (s_axis_tuser == rrf_pkg::OP_CLEAR),
        .data_byte     (s_axis_tdata),
        .window_length (tbl.window_length),
        .old_byte      (old_byte)
    );

    // Remove the departing byte, then append the new one with reduction
    assign p_word    = hash_reg ^ rrf_pkg::combine(tbl.remove_basis, old_byte);
    assign idx_shift = tbl.degree - 6'd8;
    assign p_shifted = p_word >> idx_shift;
    assign hash_push = {p_word[55:0], s1_byte_reg} ^
                       rrf_pkg::combine(tbl.append_basis, p_shifted[7:0]);
    assign hash_next = (s1_op_reg == rrf_pkg::OP_CLEAR) ? 64'd0 : hash_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hash_reg      <= 64'd0;
        end
        else
        begin
            // Load the read stage on accept, drain it on advance
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            // Update the fingerprint and fill the output register
            if (s1_adv)
            begin
                hash_reg      <= hash_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold item payloads
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= s_axis_tuser;
            s1_byte_reg <= s_axis_tdata;
        end
        if (s1_adv)
            out_data_reg <= hash_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `RRF_ASSERT_IMPLY(a_no_accept_while_deriving, clk, rst_n, tbl.busy, !s_axis_tready, "item accepted while basis words are being derived")
    `RRF_ASSERT_NEXT(a_clear_yields_zero, clk, rst_n, s1_adv && (s1_op_reg == rrf_pkg::OP_CLEAR), m_axis_tvalid && (m_axis_tdata == 64'd0) && (hash_reg == 64'd0), "clear item did not produce a zero fingerprint")
    `RRF_ASSERT_NEXT(a_read_stage_holds, clk, rst_n, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_byte_reg) && $stable(old_byte), "stalled read stage lost its item")

endmodule
